FILE: rtl/ptc_pkg.sv
package ptc_pkg;

    localparam int DivSteps = 32;

    typedef enum logic [2:0] {
        REG_CAL_A = 3'd0,
        REG_CAL_B = 3'd1,
        REG_CAL_C = 3'd2,
        REG_CAL_D = 3'd3,
        REG_CAL_E = 3'd4,
        REG_CAL_F = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_beat_t;

    typedef struct packed {
        logic signed [23:0] temperature_centidegrees;
        logic [31:0]        pressure_pascal;
        logic               pressure_valid;
    } out_beat_t;

    // One beat moving down the divider chain.
    typedef struct packed {
        logic        vld;
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic [31:0] den;
        logic [23:0] temp;
        logic        ok;
        logic        dbl;
    } div_beat_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

FILE: rtl/ptc_div_cell.sv
module ptc_div_cell
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_beat_t up,
    output div_beat_t down
);

    // One restoring step: bring in the next dividend bit, try the subtract.
    logic [32:0] trial;
    logic [32:0] diff;
    logic        take;
    div_beat_t   down_reg;
    div_beat_t   down_next;

    always_comb
    begin
        trial = {up.rem, up.num[31]};
        diff  = trial - {1'b0, up.den};
        take  = !diff[32];
        down_next      = up;
        down_next.rem  = take ? diff[31:0] : trial[31:0];
        down_next.num  = {up.num[30:0], 1'b0};
        down_next.quo  = {up.quo[30:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg <= '0;
        end
        else
        begin
            down_reg <= down_next;
        end
    end

    assign down = down_reg;

endmodule

FILE: rtl/pressure_temperature_compensation.sv
// done goes high together with its result, once the beat has passed the input registers,
// the divider chain and the final correction registers.
// Throughput: one beat per cycle; busy is never raised, so a beat may follow every cycle.
// The divider is a chain of 32 cells, one quotient bit each, so it sets the latency.
// Reset (rst_n low, asynchronous) clears all calibration words and every stage valid bit.
// The receiver cannot stall: each result stands on the result port for exactly one cycle.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_beat_t    sample,
    output logic        done,
    output out_beat_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Calibration words. The user must change configuration only while the pipeline
    // is empty; the block does not enforce it. Every stage reads these registers directly.
    logic [31:0] cal_a_reg, cal_b_reg, cal_c_reg, cal_d_reg, cal_e_reg, cal_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            cal_d_reg <= '0;
            cal_e_reg <= '0;
            cal_f_reg <= '0;
        end
        else if (cfg_valid)
        begin
            // Writes to an index past the last word are dropped.
            unique case (reg_index_t'(cfg_index))
                REG_CAL_A: cal_a_reg <= cfg_data;
                REG_CAL_B: cal_b_reg <= cfg_data;
                REG_CAL_C: cal_c_reg <= cfg_data;
                REG_CAL_D: cal_d_reg <= cfg_data;
                REG_CAL_E: cal_e_reg <= cfg_data;
                REG_CAL_F: cal_f_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Coefficients unpacked from the words.
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, cal_a_reg[15:0]};
    assign t2 = sx16(cal_a_reg[31:16]);
    assign t3 = sx16(cal_b_reg[15:0]);
    assign p1 = {16'd0, cal_b_reg[31:16]};
    assign p2 = sx16(cal_c_reg[15:0]);
    assign p3 = sx16(cal_c_reg[31:16]);
    assign p4 = sx16(cal_d_reg[15:0]);
    assign p5 = sx16(cal_d_reg[31:16]);
    assign p6 = sx16(cal_e_reg[15:0]);
    assign p7 = sx16(cal_e_reg[31:16]);
    assign p8 = sx16(cal_f_reg[15:0]);
    assign p9 = sx16(cal_f_reg[31:16]);

    // All arithmetic below wraps at 32 bits; right shifts of intermediates are
    // arithmetic, which $signed(...) >>> gives.
    logic [10:1] vld_reg;
    logic [19:0] adcp1_reg, adcp2_reg, adcp3_reg, adcp4_reg, adcp5_reg;
    logic [19:0] adcp6_reg, adcp7_reg, adcp8_reg, adcp9_reg;
    logic [31:0] x1_reg, d_reg, m1_reg, dd_reg, ta_reg, m2_reg, fine_reg;
    logic [31:0] t5_reg, pa_reg, sq_reg, ap5_reg, ap2_reg, ap5b_reg, ap2b_reg;
    logic [31:0] b1_reg, c1_reg, pb_reg, a2_reg, divm_reg, pb9_reg;
    logic [31:0] den_reg, pnum_reg;
    logic [23:0] temp6_reg, temp7_reg, temp8_reg, temp9_reg, temp10_reg;
    logic [31:0] ta_next, fine_next, pa_next, q_next, pb_next, a2_next, den_next;

    always_comb
    begin
        ta_next   = 32'($signed(m1_reg) >>> 11);
        fine_next = ta_reg + 32'($signed(m2_reg) >>> 14);
        pa_next   = 32'($signed(fine_reg) >>> 1) - 32'd64000;
        q_next    = 32'($signed(pa_reg) >>> 2);
        pb_next   = 32'($signed(b1_reg + {ap5b_reg[30:0], 1'b0}) >>> 2)
                  + {p4[15:0], 16'd0};
        a2_next   = 32'($signed(32'($signed(c1_reg) >>> 3)
                  + 32'($signed(ap2b_reg) >>> 1)) >>> 18);
        den_next  = 32'($signed(divm_reg) >>> 15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[9:1], start && !busy};
        end
    end

    always_ff @(posedge clk)
    begin
        // Temperature offsets.
        x1_reg    <= {15'd0, sample.raw_temperature[19:3]} - {t1[30:0], 1'b0};
        d_reg     <= {16'd0, sample.raw_temperature[19:4]} - t1;
        adcp1_reg <= sample.raw_pressure;
        // First products.
        m1_reg    <= x1_reg * t2;
        dd_reg    <= d_reg * d_reg;
        adcp2_reg <= adcp1_reg;
        ta_reg    <= ta_next;
        m2_reg    <= 32'($signed(dd_reg) >>> 12) * t3;
        adcp3_reg <= adcp2_reg;
        // Fine temperature.
        fine_reg  <= fine_next;
        adcp4_reg <= adcp3_reg;
        t5_reg    <= {fine_reg[29:0], 2'b00} + fine_reg + 32'd128;
        pa_reg    <= pa_next;
        adcp5_reg <= adcp4_reg;
        // Pressure products on the offset fine temperature.
        temp6_reg <= 24'($signed(t5_reg) >>> 8);
        sq_reg    <= q_next * q_next;
        ap5_reg   <= pa_reg * p5;
        ap2_reg   <= p2 * pa_reg;
        adcp6_reg <= adcp5_reg;
        temp7_reg <= temp6_reg;
        b1_reg    <= 32'($signed(sq_reg) >>> 11) * p6;
        c1_reg    <= p3 * 32'($signed(sq_reg) >>> 13);
        ap5b_reg  <= ap5_reg;
        ap2b_reg  <= ap2_reg;
        adcp7_reg <= adcp6_reg;
        temp8_reg <= temp7_reg;
        pb_reg    <= pb_next;
        a2_reg    <= a2_next;
        adcp8_reg <= adcp7_reg;
        // Divisor product.
        temp9_reg <= temp8_reg;
        divm_reg  <= (32'd32768 + a2_reg) * p1;
        pb9_reg   <= pb_reg;
        adcp9_reg <= adcp8_reg;
        // Divisor and dividend.
        temp10_reg <= temp9_reg;
        den_reg    <= den_next;
        pnum_reg   <= ((32'd1048576 - {12'd0, adcp9_reg})
                     - 32'($signed(pb9_reg) >>> 12)) * 32'd3125;
    end

    // Divider chain. Below 0x80000000 the dividend is doubled before the divide,
    // otherwise the quotient is doubled after it.
    div_beat_t div_head;
    div_beat_t chain [0:DivSteps];

    always_comb
    begin
        div_head.vld  = vld_reg[10];
        div_head.rem  = '0;
        div_head.dbl  = pnum_reg[31];
        div_head.num  = pnum_reg[31] ? pnum_reg : {pnum_reg[30:0], 1'b0};
        div_head.quo  = '0;
        div_head.den  = den_reg;
        div_head.temp = temp10_reg;
        div_head.ok   = (den_reg != 32'd0);
    end

    assign chain[0] = div_head;

    for (genvar g = 0; g < DivSteps; g++)
    begin : g_div
        ptc_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (chain[g]),
            .down  (chain[g + 1])
        );
    end

    // Final correction on the quotient.
    div_beat_t   dq;
    logic [31:0] qf;
    logic [2:0]  post_vld_reg;
    logic [31:0] qf12_reg, pp_reg, m8_reg, qf13_reg, ca_reg, cb_reg;
    logic [23:0] temp12_reg, temp13_reg;
    logic        ok12_reg, ok13_reg;
    out_beat_t   result_reg;
    logic [31:0] corr;

    assign dq   = chain[DivSteps];
    assign qf   = dq.dbl ? {dq.quo[30:0], 1'b0} : dq.quo;
    assign corr = 32'($signed(ca_reg + cb_reg + p7) >>> 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_vld_reg <= '0;
        end
        else
        begin
            post_vld_reg <= {post_vld_reg[1:0], dq.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        qf12_reg   <= qf;
        pp_reg     <= {3'd0, qf[31:3]} * {3'd0, qf[31:3]};
        m8_reg     <= {2'd0, qf[31:2]} * p8;
        temp12_reg <= dq.temp;
        ok12_reg   <= dq.ok;
        qf13_reg   <= qf12_reg;
        ca_reg     <= 32'($signed(p9 * {13'd0, pp_reg[31:13]}) >>> 12);
        cb_reg     <= 32'($signed(m8_reg) >>> 13);
        temp13_reg <= temp12_reg;
        ok13_reg   <= ok12_reg;
        result_reg.temperature_centidegrees <= temp13_reg;
        result_reg.pressure_pascal          <= ok13_reg ? (qf13_reg + corr) : 32'd0;
        result_reg.pressure_valid           <= ok13_reg;
    end

    assign done   = post_vld_reg[2];
    assign result = result_reg;

endmodule
